>>> rtl/section_point_thinning_top_macros.svh
// Assertion macros shared by the section point thinning RTL.
`ifndef SECTION_POINT_THINNING_TOP_MACROS_SVH
`define SECTION_POINT_THINNING_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/spt_pkg.sv
// Shared types and constants for the section point thinning block.
package spt_pkg;

	localparam int SLOPE_W   = 32;
	localparam int COORD_W   = 32;
	localparam int ID_W      = 16;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 1;
	localparam int PS_W      = 2;

	localparam logic [SLOPE_W-1:0] SLOPE_MAX     = 32'h7FFF_FFFF;
	localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = 32'h8000_0001;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SLOPE_CHANGE = 1'b1;

	// points held for the current section (grade points not counted)
	localparam logic [PS_W-1:0] PS_NONE   = 2'd0;
	localparam logic [PS_W-1:0] PS_ANCHOR = 2'd1;
	localparam logic [PS_W-1:0] PS_CAND   = 2'd2;

	typedef enum logic [2:0] {
		W_IDLE,
		W_DISPATCH,
		W_WAIT_CUR,
		W_DECIDE,
		W_EMIT_CAND,
		W_EMIT_PT,
		W_WAIT_PREV
	} walk_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_ABS,
		DV_ITER,
		DV_SIGN
	} div_state_t;

	// status of the shared slope divider
	typedef struct packed {
		logic                      busy;
		logic                      done;
		logic signed [SLOPE_W-1:0] slope;
	} div_rsp_t;

endpackage

>>> rtl/section_point_thinning_top.sv
// Top level of the section point thinning block: ports, configuration registers, packing.
//
//  channel  dir  transaction
//  s_*      in   one profile point: tdata {point_id, y, x}, tuser {keep_forced, grade_marker},
//                tlast section_last
//  m_*      out  one verdict: tdata {out_y, out_x, out_id}, tuser {run_end, keep},
//                tlast section_end
//  cfg_*    in   register write, index 0 min_spacing, 1 min_slope_change
//
// A point is accepted only while the sequencer is idle; each slope is formed on the shared serial
// divider, which saturates at once on a zero x step. A point with no slope to form goes straight
// to the output. Otherwise the point waits on the divider; a dropped candidate runs it a second
// time, for the slope from the anchor to the new candidate.
// Asynchronous reset clears the walk and both registers; there is no clearing pass.
// A stalled m_tready holds at most one verdict in the output register and stops the sequencer.
module section_point_thinning_top
	import spt_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int SLOPE_FRAC  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [79:0]          s_tdata,   // x[31:0], y[63:32], point_id[79:64]
	input  logic                 s_tlast,
	input  logic [1:0]           s_tuser,   // grade_marker[0], keep_forced[1]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [79:0]          m_tdata,   // out_id[15:0], out_x[47:16], out_y[79:48]
	output logic                 m_tlast,
	output logic [1:0]           m_tuser,   // keep[0], run_end[1]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CWE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

	logic [CFG_W-1:0]   min_spacing_q, min_slope_change_q;
	logic [ID_W-1:0]    out_id;
	logic [COORD_W-1:0] out_x, out_y;
	logic               out_keep, out_run_end;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_spacing_q      <= '0;
			min_slope_change_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_SPACING:      min_spacing_q      <= cfg_data;
				REG_MIN_SLOPE_CHANGE: min_slope_change_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spt_walk #(
		.CWE        (CWE),
		.SLOPE_FRAC (SLOPE_FRAC)
	) u_walk (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.in_x             (s_tdata[31:0]),
		.in_y             (s_tdata[63:32]),
		.in_id            (s_tdata[79:64]),
		.in_grade         (s_tuser[0]),
		.in_forced        (s_tuser[1]),
		.in_last          (s_tlast),
		.min_spacing      (min_spacing_q),
		.min_slope_change (min_slope_change_q),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.out_id           (out_id),
		.out_x            (out_x),
		.out_y            (out_y),
		.out_keep         (out_keep),
		.out_run_end      (out_run_end),
		.out_section_end  (m_tlast)
	);

	// result packing
	assign m_tdata = {out_y, out_x, out_id};
	assign m_tuser = {out_run_end, out_keep};

endmodule

>>> rtl/spt_div.sv
// Serial restoring divider that forms the saturated fixed-point slope of two points.
module spt_div
	import spt_pkg::*;
#(
	parameter int CWE        = 32,
	parameter int SLOPE_FRAC = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [CWE-1:0] a_x,
	input  logic signed [CWE-1:0] a_y,
	input  logic signed [CWE-1:0] b_x,
	input  logic signed [CWE-1:0] b_y,
	output div_rsp_t              rsp
);

	localparam int DW    = CWE + 1;
	localparam int NB    = DW + SLOPE_FRAC;
	localparam int CNT_W = $clog2(NB);
	localparam int QW    = SLOPE_W - 1;

	div_state_t                state_q, state_d;
	logic signed [DW-1:0]      dx_q, dy_q;
	logic [DW-1:0]             den_q, rem_q;
	logic [NB-1:0]             num_q;
	logic [QW-1:0]             quo_q;
	logic                      ovf_q, neg_q, done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [SLOPE_W-1:0] res_q;

	logic [DW-1:0]  dx_mag, dy_mag;
	logic [DW:0]    rem_sh;
	logic [DW+1:0]  trial;
	logic           ge;
	logic [SLOPE_W-1:0] mag;

	// magnitudes of the step
	assign dx_mag = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
	assign dy_mag = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);

	// one restoring step: shift in next dividend bit, trial subtract
	assign rem_sh = {rem_q, num_q[NB-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge     = !trial[DW+1];

	// saturated magnitude
	assign mag = ovf_q ? SLOPE_MAX : {1'b0, quo_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_ABS;
			DV_ABS:  state_d = (dx_q == '0) ? DV_IDLE : DV_ITER;
			DV_ITER: if (cnt_q == '0) state_d = DV_SIGN;
			DV_SIGN: state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == DV_ABS) && (dx_q == '0)) || (state_q == DV_SIGN);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			DV_IDLE: begin
				if (start) begin
					dx_q <= DW'(b_x) - DW'(a_x);
					dy_q <= DW'(b_y) - DW'(a_y);
				end
			end
			DV_ABS: begin
				neg_q <= dy_q[DW-1] != dx_q[DW-1];
				if (dx_q == '0) begin
					// vertical step saturates
					res_q <= dy_q[DW-1] ? SLOPE_NEG_MAX : SLOPE_MAX;
				end else begin
					den_q <= dx_mag;
					num_q <= {dy_mag, SLOPE_FRAC'(0)};
					rem_q <= '0;
					quo_q <= '0;
					ovf_q <= 1'b0;
					cnt_q <= CNT_W'(NB - 1);
				end
			end
			DV_ITER: begin
				rem_q <= ge ? trial[DW-1:0] : rem_sh[DW-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[QW-2:0], ge};
				ovf_q <= ovf_q | quo_q[QW-1];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			DV_SIGN: begin
				res_q <= neg_q ? SLOPE_W'(-mag) : mag;
			end
			default: ;
		endcase
	end

	assign rsp.busy  = (state_q != DV_IDLE);
	assign rsp.done  = done_q;
	assign rsp.slope = res_q;

endmodule

>>> rtl/spt_walk.sv
// Sequencer of the thinning walk: anchor and candidate state, verdicts, output register.
`include "section_point_thinning_top_macros.svh"

module spt_walk
	import spt_pkg::*;
#(
	parameter int CWE        = 32,
	parameter int SLOPE_FRAC = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_W-1:0]        in_x,
	input  logic [COORD_W-1:0]        in_y,
	input  logic [ID_W-1:0]           in_id,
	input  logic                      in_grade,
	input  logic                      in_forced,
	input  logic                      in_last,
	input  logic [CFG_W-1:0]          min_spacing,
	input  logic [CFG_W-1:0]          min_slope_change,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ID_W-1:0]           out_id,
	output logic [COORD_W-1:0]        out_x,
	output logic [COORD_W-1:0]        out_y,
	output logic                      out_keep,
	output logic                      out_run_end,
	output logic                      out_section_end
);

	localparam int SPW = (CWE >= 32) ? CWE + 1 : 32;

	walk_state_t state_q, state_d;
	logic [PS_W-1:0] ps_q;

	// current point
	logic signed [CWE-1:0] p_x_q, p_y_q;
	logic [ID_W-1:0]       p_id_q;
	logic                  p_grade_q, p_forced_q, p_last_q;

	// walk state
	logic signed [CWE-1:0]     anchor_x_q, anchor_y_q, cand_x_q, cand_y_q;
	logic [ID_W-1:0]           cand_id_q;
	logic                      cand_forced_q, cand_keep_q, drop_q;
	logic signed [SLOPE_W-1:0] prev_q, cur_q;

	// output register
	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic [COORD_W-1:0]  out_x_q, out_y_q;
	logic                out_keep_q, out_run_end_q, out_section_end_q;

	logic                  out_free, div_start, div_from_cand, load_cand, load_pt;
	logic signed [CWE-1:0] div_ax, div_ay;
	div_rsp_t              div_rsp;

	logic signed [SPW-1:0] span;
	logic signed [SLOPE_W:0] sdiff;
	logic [SLOPE_W:0]        adiff;
	logic                    drop;

	assign out_free = !out_valid_q || out_ready;

	// drop test on the candidate
	assign span  = SPW'(cand_x_q) - SPW'(anchor_x_q);
	assign sdiff = (SLOPE_W+1)'(cur_q) - (SLOPE_W+1)'(prev_q);
	assign adiff = sdiff[SLOPE_W] ? (SLOPE_W+1)'(-sdiff) : (SLOPE_W+1)'(sdiff);
	assign drop  = (span < $signed(SPW'(min_spacing))) &&
	               (adiff < {2'b00, min_slope_change});

	// shared slope divider, second point is always the current one
	assign div_ax = div_from_cand ? cand_x_q : anchor_x_q;
	assign div_ay = div_from_cand ? cand_y_q : anchor_y_q;

	spt_div #(
		.CWE        (CWE),
		.SLOPE_FRAC (SLOPE_FRAC)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a_x    (div_ax),
		.a_y    (div_ay),
		.b_x    (p_x_q),
		.b_y    (p_y_q),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			W_IDLE: if (in_valid) state_d = W_DISPATCH;
			W_DISPATCH: begin
				if (p_grade_q) begin
					state_d = (p_last_q && ps_q == PS_CAND) ? W_EMIT_CAND : W_EMIT_PT;
				end else begin
					case (ps_q)
						PS_NONE:   state_d = W_EMIT_PT;
						PS_ANCHOR: state_d = p_last_q ? W_EMIT_PT : W_WAIT_PREV;
						default:   state_d = W_WAIT_CUR;
					endcase
				end
			end
			W_WAIT_CUR:  if (div_rsp.done) state_d = W_DECIDE;
			W_DECIDE:    state_d = W_EMIT_CAND;
			W_EMIT_CAND: begin
				if (out_free) begin
					if (p_grade_q || p_last_q) state_d = W_EMIT_PT;
					else if (drop_q)           state_d = W_WAIT_PREV;
					else                       state_d = W_IDLE;
				end
			end
			W_EMIT_PT:   if (out_free) state_d = W_IDLE;
			W_WAIT_PREV: if (div_rsp.done) state_d = W_IDLE;
			default:     state_d = W_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready      = 1'b0;
		div_start     = 1'b0;
		div_from_cand = 1'b0;
		load_cand     = 1'b0;
		load_pt       = 1'b0;
		unique case (state_q)
			W_IDLE: in_ready = 1'b1;
			W_DISPATCH: begin
				div_from_cand = (ps_q == PS_CAND);
				div_start     = !p_grade_q &&
				                ((ps_q == PS_ANCHOR && !p_last_q) || ps_q == PS_CAND);
			end
			W_EMIT_CAND: begin
				load_cand = out_free;
				div_start = out_free && !p_grade_q && !p_last_q && drop_q;
			end
			W_EMIT_PT: load_pt = out_free;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= W_IDLE;
			ps_q        <= PS_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == W_WAIT_PREV && div_rsp.done) begin
				ps_q <= PS_CAND;
			end else if (load_pt) begin
				if (p_last_q)                        ps_q <= PS_NONE;
				else if (!p_grade_q && ps_q == PS_NONE) ps_q <= PS_ANCHOR;
			end
			if (load_cand || load_pt) out_valid_q <= 1'b1;
			else if (out_ready)       out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && in_valid) begin
			p_x_q      <= in_x[CWE-1:0];
			p_y_q      <= in_y[CWE-1:0];
			p_id_q     <= in_id;
			p_grade_q  <= in_grade;
			p_forced_q <= in_forced;
			p_last_q   <= in_last;
		end
		if (state_q == W_DISPATCH) begin
			if (p_grade_q) cand_keep_q <= 1'b1;
			else if (ps_q == PS_NONE) begin
				anchor_x_q <= p_x_q;
				anchor_y_q <= p_y_q;
			end
		end
		if (state_q == W_WAIT_CUR && div_rsp.done) cur_q <= div_rsp.slope;
		if (state_q == W_DECIDE) begin
			drop_q      <= drop;
			cand_keep_q <= !drop || cand_forced_q;
		end
		// candidate kept: it becomes the anchor
		if (load_cand && !p_grade_q && !p_last_q && !drop_q) begin
			anchor_x_q    <= cand_x_q;
			anchor_y_q    <= cand_y_q;
			prev_q        <= cur_q;
			cand_x_q      <= p_x_q;
			cand_y_q      <= p_y_q;
			cand_id_q     <= p_id_q;
			cand_forced_q <= p_forced_q;
		end
		// slope from the anchor to the new candidate
		if (state_q == W_WAIT_PREV && div_rsp.done) begin
			prev_q        <= div_rsp.slope;
			cand_x_q      <= p_x_q;
			cand_y_q      <= p_y_q;
			cand_id_q     <= p_id_q;
			cand_forced_q <= p_forced_q;
		end
		// output register load
		if (load_cand) begin
			out_id_q          <= cand_id_q;
			out_x_q           <= COORD_W'(cand_x_q);
			out_y_q           <= COORD_W'(cand_y_q);
			out_keep_q        <= cand_keep_q;
			out_run_end_q     <= !p_last_q;
			out_section_end_q <= 1'b0;
		end else if (load_pt) begin
			out_id_q          <= p_id_q;
			out_x_q           <= COORD_W'(p_x_q);
			out_y_q           <= COORD_W'(p_y_q);
			out_keep_q        <= 1'b1;
			out_run_end_q     <= 1'b1;
			out_section_end_q <= p_last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_id          = out_id_q;
	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign out_keep        = out_keep_q;
	assign out_run_end     = out_run_end_q;
	assign out_section_end = out_section_end_q;

	`SPT_ASSERT_NOW(a_div_start_free, div_start, !div_rsp.busy, "divider started while busy")
	`SPT_ASSERT_NOW(a_ready_div_quiet, in_ready, !div_rsp.busy && !div_rsp.done, "accepting while divider active")
	`SPT_ASSERT_NOW(a_done_awaited, div_rsp.done, state_q == W_WAIT_CUR || state_q == W_WAIT_PREV, "unexpected divider result")
	`SPT_ASSERT_NEXT(a_pt_closes_run, load_pt, out_valid_q && out_run_end_q, "point verdict does not close run")

endmodule
